>>> rtl/clvd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clvd_pkg
// Shared widths, codes and defaults for the contact link vote detector.
// ----------------------------------------------------------------------------
package clvd_pkg;

   localparam int JOINTS_DEF = 7;
   localparam int WINDOW_DEF = 20;

   localparam int RES_W      = 16;
   localparam int THR_W      = 15;
   localparam int JOINT_W    = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [JOINT_W-1:0] NONE_JOINT   = 3'd7;
   localparam logic [THR_W-1:0]   THRESH_RESET = 15'd38;

   localparam logic REG_DETECT_THRESHOLD = 1'b0;

endpackage : clvd_pkg
`default_nettype wire

>>> rtl/clvd_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clvd_req_if
// Request channel: seven signed Q8.8 joint residuals per item.
// ----------------------------------------------------------------------------
interface clvd_req_if;
   import clvd_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [RES_W-1:0] residual_0;
   logic signed [RES_W-1:0] residual_1;
   logic signed [RES_W-1:0] residual_2;
   logic signed [RES_W-1:0] residual_3;
   logic signed [RES_W-1:0] residual_4;
   logic signed [RES_W-1:0] residual_5;
   logic signed [RES_W-1:0] residual_6;

   modport source (
      output valid, residual_0, residual_1, residual_2, residual_3,
             residual_4, residual_5, residual_6,
      input  ready
   );

   modport sink (
      input  valid, residual_0, residual_1, residual_2, residual_3,
             residual_4, residual_5, residual_6,
      output ready
   );

endinterface : clvd_req_if
`default_nettype wire

>>> rtl/clvd_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clvd_rsp_if
// Response channel: contact flag, reported joint, raw joint, contact loss.
// ----------------------------------------------------------------------------
interface clvd_rsp_if;
   import clvd_pkg::*;

   logic               valid;
   logic               ready;
   logic               contact_on;
   logic [JOINT_W-1:0] contact_joint;
   logic [JOINT_W-1:0] raw_joint;
   logic               lost_contact;

   modport source (
      output valid, contact_on, contact_joint, raw_joint, lost_contact,
      input  ready
   );

   modport sink (
      input  valid, contact_on, contact_joint, raw_joint, lost_contact,
      output ready
   );

endinterface : clvd_rsp_if
`default_nettype wire

>>> rtl/clvd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clvd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clvd_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 20,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule : clvd_ram
`default_nettype wire

>>> rtl/contact_link_vote_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// contact_link_vote_detector
// Per-tick joint contact vote over a sliding window of raw detections.
// ----------------------------------------------------------------------------
// One item is accepted every clock cycle while the input is not stalled; the
// edge at which stage one advances loads the result into the output register.
// Stage one takes the raw joint computed from the residuals while the ring
// RAM reads the slot being replaced; on advancing, the per-joint counts and
// the filled count are updated, the slot is written back and the majority
// joint is picked. A stalled result holds one further item in the first
// stage, and the input stalls only while both are full. A write-to-read
// forward covers a one-slot window. The ring needs no clearing pass after
// reset: a wrap flag marks slots that were never written as empty.
// ----------------------------------------------------------------------------
module contact_link_vote_detector #(
   parameter int JOINTS = clvd_pkg::JOINTS_DEF,
   parameter int WINDOW = clvd_pkg::WINDOW_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   clvd_req_if.sink                              req_chan,
   clvd_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [clvd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [clvd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [clvd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                  csr_pready
);
   import clvd_pkg::*;

   localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W = $clog2(WINDOW + 1);

   // configuration
   logic [THR_W-1:0] thr_ff;
   logic             csr_wr;

   // ring position and stage one
   logic [POS_W-1:0]   pos_ff;
   logic               wrapped_ff;
   logic               s1_valid_ff;
   logic [JOINT_W-1:0] s1_raw_ff;
   logic [POS_W-1:0]   s1_pos_ff;
   logic               s1_old_ok_ff;
   logic               fwd_ff;
   logic [JOINT_W-1:0] fwd_data_ff;

   // vote state
   logic [CNT_W-1:0] counts_ff [JOINTS];
   logic [CNT_W-1:0] counts_in [JOINTS];
   logic [CNT_W-1:0] filled_ff;
   logic [CNT_W-1:0] filled_in;
   logic             contact_ff;
   logic             contact_in;

   // output register
   logic               rsp_valid_ff;
   logic               rsp_contact_ff;
   logic [JOINT_W-1:0] rsp_joint_ff;
   logic [JOINT_W-1:0] rsp_raw_ff;
   logic               rsp_lost_ff;

   logic                    accept;
   logic                    s1_adv;
   logic                    pos_wrap;
   logic signed [RES_W-1:0] res_arr [7];
   logic [JOINT_W-1:0]      raw_in;
   logic [POS_W-1:0]        ram_raddr;
   logic [JOINT_W-1:0]      ram_rdata;
   logic [JOINT_W-1:0]      old_joint;
   logic [JOINT_W-1:0]      best_in;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_DETECT_THRESHOLD)
                       ? CSR_DATA_W'(thr_ff) : '0;

   assign s1_adv         = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign accept         = req_chan.valid && req_chan.ready;
   assign pos_wrap       = (pos_ff == POS_W'(WINDOW - 1));

   assign res_arr[0] = req_chan.residual_0;
   assign res_arr[1] = req_chan.residual_1;
   assign res_arr[2] = req_chan.residual_2;
   assign res_arr[3] = req_chan.residual_3;
   assign res_arr[4] = req_chan.residual_4;
   assign res_arr[5] = req_chan.residual_5;
   assign res_arr[6] = req_chan.residual_6;

   always_comb begin
      logic [RES_W:0] ext;
      logic [RES_W:0] mag;
      raw_in = NONE_JOINT;
      for (int i = 0; i < JOINTS; i++) begin
         ext = {res_arr[i][RES_W-1], res_arr[i]};
         mag = ext[RES_W] ? (~ext + 1'b1) : ext;
         if (mag > (RES_W+1)'(thr_ff)) begin
            raw_in = JOINT_W'(i);
         end
      end
   end

   // hold the read on the stalled slot so the data stays valid
   assign ram_raddr = (s1_valid_ff && !s1_adv) ? s1_pos_ff : pos_ff;

   clvd_ram #(
      .WIDTH (JOINT_W),
      .DEPTH (WINDOW),
      .ADDR_W(POS_W)
   ) u_ring (
      .clock     (clock),
      .wr_en     (s1_adv),
      .wr_addr   (s1_pos_ff),
      .wr_data   (s1_raw_ff),
      .rd_addr   (ram_raddr),
      .rd_data_ff(ram_rdata)
   );

   assign old_joint = !s1_old_ok_ff ? NONE_JOINT : (fwd_ff ? fwd_data_ff : ram_rdata);

   always_comb begin
      logic [CNT_W-1:0] best_cnt;
      for (int j = 0; j < JOINTS; j++) begin
         counts_in[j] = counts_ff[j]
                        - CNT_W'(old_joint == JOINT_W'(j))
                        + CNT_W'(s1_raw_ff == JOINT_W'(j));
      end
      filled_in = filled_ff
                  - CNT_W'(old_joint < JOINT_W'(JOINTS))
                  + CNT_W'(s1_raw_ff < JOINT_W'(JOINTS));
      if (filled_in >= CNT_W'(WINDOW)) begin
         contact_in = 1'b1;
      end else if (filled_in == '0) begin
         contact_in = 1'b0;
      end else begin
         contact_in = contact_ff;
      end
      best_in  = '0;
      best_cnt = counts_in[0];
      for (int j = 1; j < JOINTS; j++) begin
         if (counts_in[j] > best_cnt) begin
            best_in  = JOINT_W'(j);
            best_cnt = counts_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THRESH_RESET;
         pos_ff       <= '0;
         wrapped_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         filled_ff    <= '0;
         contact_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < JOINTS; j++) begin
            counts_ff[j] <= '0;
         end
      end else begin
         if (csr_wr && (csr_paddr[2] == REG_DETECT_THRESHOLD)) begin
            thr_ff <= csr_pwdata[THR_W-1:0];
         end
         fwd_ff <= s1_adv && (s1_pos_ff == ram_raddr);
         if (accept) begin
            pos_ff      <= pos_wrap ? '0 : pos_ff + 1'b1;
            s1_valid_ff <= 1'b1;
            if (pos_wrap) begin
               wrapped_ff <= 1'b1;
            end
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            filled_ff    <= filled_in;
            contact_ff   <= contact_in;
            rsp_valid_ff <= 1'b1;
            for (int j = 0; j < JOINTS; j++) begin
               counts_ff[j] <= counts_in[j];
            end
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         s1_raw_ff    <= raw_in;
         s1_pos_ff    <= pos_ff;
         s1_old_ok_ff <= wrapped_ff;
      end
      fwd_data_ff <= s1_raw_ff;
      if (s1_adv) begin
         rsp_contact_ff <= contact_in;
         rsp_joint_ff   <= contact_in ? best_in : s1_raw_ff;
         rsp_raw_ff     <= s1_raw_ff;
         rsp_lost_ff    <= contact_ff && !contact_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.contact_on    = rsp_contact_ff;
   assign rsp_chan.contact_joint = rsp_joint_ff;
   assign rsp_chan.raw_joint     = rsp_raw_ff;
   assign rsp_chan.lost_contact  = rsp_lost_ff;

endmodule : contact_link_vote_detector
`default_nettype wire

>>> rtl/clvd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clvd_checker
// Port-level checks on the response channel of the vote detector.
// ----------------------------------------------------------------------------
module clvd_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   input  wire logic                         rsp_contact_on,
   input  wire logic [clvd_pkg::JOINT_W-1:0] rsp_contact_joint,
   input  wire logic [clvd_pkg::JOINT_W-1:0] rsp_raw_joint,
   input  wire logic                         rsp_lost_contact
);
   import clvd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_contact_on) && $stable(rsp_contact_joint)
                                  && $stable(rsp_raw_joint) && $stable(rsp_lost_contact))
      else $error("rsp payload changed while stalled");

   a_lost_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lost_contact |-> !rsp_contact_on)
      else $error("lost contact reported while in contact");

   a_raw_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_contact_on |-> rsp_contact_joint == rsp_raw_joint)
      else $error("out of contact joint differs from raw joint");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule : clvd_checker

bind contact_link_vote_detector clvd_checker u_clvd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_contact_on   (rsp_chan.contact_on),
   .rsp_contact_joint(rsp_chan.contact_joint),
   .rsp_raw_joint    (rsp_chan.raw_joint),
   .rsp_lost_contact (rsp_chan.lost_contact)
);
`default_nettype wire
